// File: hw/rtl/servo_ramp_position_stepper_defines.svh
// assertion macros for the servo ramp position stepper checker
// expects signals clk and rst in the scope where a macro is used
`ifndef SERVO_RAMP_POSITION_STEPPER_DEFINES_SVH
`define SERVO_RAMP_POSITION_STEPPER_DEFINES_SVH

// condition holds in the same cycle as the antecedent
`define SRPS_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the antecedent
`define SRPS_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/srps_pkg.sv
// shared types, constants and the slow-down table of the servo ramp stepper
// no dependencies
package srps_pkg;

  // configuration port
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MAX = 2'd3;

  // configuration reset values
  localparam logic signed [CFG_W-1:0] EXT_MIN_RST = 16'sd0;
  localparam logic signed [CFG_W-1:0] EXT_MAX_RST = 16'sd180;
  localparam logic signed [CFG_W-1:0] INT_MIN_RST = 16'sd0;
  localparam logic signed [CFG_W-1:0] INT_MAX_RST = 16'sd180;

  // item actions
  localparam logic ACT_MOVE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // range mapping widths: 17-bit differences, 34-bit product
  localparam int DIFF_W = CFG_W + 1;
  localparam int MAP_W = 2 * DIFF_W;

  // divider: 32-bit magnitude over 16-bit magnitude, two quotient bits a cycle
  localparam int DVD_W = 32;
  localparam int DSR_W = 16;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // step and slow-down widths
  localparam int STEP_W = 3;
  localparam int LIMIT_W = 5;
  localparam logic [STEP_W-1:0] STEP_MAX = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // slow-down limit for step s: s*(s+1)/2 + 1
  function automatic logic [LIMIT_W-1:0] slow_limit(input logic [STEP_W-1:0] s);
    logic [LIMIT_W-1:0] lim;
    case (s)
      3'd0: lim = 5'd1;
      3'd1: lim = 5'd2;
      3'd2: lim = 5'd4;
      3'd3: lim = 5'd7;
      3'd4: lim = 5'd11;
      3'd5: lim = 5'd16;
      3'd6: lim = 5'd22;
      default: lim = 5'd29;
    endcase
    return lim;
  endfunction

endpackage

// File: hw/rtl/servo_ramp_position_stepper.sv
// move word: multiply, load, divide (skipped for a zero-width external range), fix-up,
// target update, then output once the result register is free to take it
// tick word: tick, move, output (move skipped at target); next accepted once back in idle
// one result per word, held in an output register; a new word may be taken meanwhile
// rst (synchronous): config 0/180/0/180, position, target, step and limit zero
module servo_ramp_position_stepper #(
  parameter int POS_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [srps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srps_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic signed [15:0]                  command_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  position,
  output logic                                at_target,
  output logic [srps_pkg::STEP_W-1:0]         step_size
);

  localparam int PW = POS_WIDTH;
  localparam int MW = srps_pkg::MAP_W;
  localparam logic signed [63:0] POS_MAX64 = (64'sd1 <<< (PW - 1)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN64 = -(64'sd1 <<< (PW - 1));
  localparam logic signed [MW-1:0] MAP_MAX = POS_MAX64[MW-1:0];
  localparam logic signed [MW-1:0] MAP_MIN = POS_MIN64[MW-1:0];
  localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  // sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_LOAD = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_FIX  = 4'd4;
  localparam logic [3:0] ST_TGT  = 4'd5;
  localparam logic [3:0] ST_TICK = 4'd6;
  localparam logic [3:0] ST_MOVE = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state;

  // configuration registers
  logic signed [srps_pkg::CFG_W-1:0] ext_min;
  logic signed [srps_pkg::CFG_W-1:0] ext_max;
  logic signed [srps_pkg::CFG_W-1:0] int_min;
  logic signed [srps_pkg::CFG_W-1:0] int_max;

  // motion state
  logic signed [PW-1:0]              target_position;
  logic signed [PW-1:0]              current_position;
  logic [srps_pkg::STEP_W-1:0]       step_width;
  logic [srps_pkg::LIMIT_W-1:0]      slowdown_limit;

  // mapping working registers
  logic signed [srps_pkg::DIFF_W-1:0] num_a;
  logic signed [srps_pkg::DIFF_W-1:0] num_b;
  logic signed [srps_pkg::DIFF_W-1:0] span;
  logic                               zero_span;
  logic signed [MW-1:0]               prod;
  logic                               neg;
  logic signed [PW-1:0]               mapped;
  logic                               dir_down;

  // divider hookup
  logic                               div_start;
  logic [srps_pkg::DVD_W-1:0]         div_q;
  srps_pkg::div_stat_t                div_stat;
  logic [MW-1:0]                      prod_mag;
  logic [srps_pkg::DIFF_W-1:0]        span_mag;

  // combinational helpers
  logic                               in_acc;
  logic                               out_load;
  logic [srps_pkg::DVD_W-1:0]         q_use;
  logic signed [MW-1:0]               q_ext;
  logic signed [MW-1:0]               q_sgn;
  logic signed [MW-1:0]               map_sum;
  logic signed [PW:0]                 sub_rhs;
  logic signed [PW:0]                 delta;
  logic [PW:0]                        gap_abs;
  logic [srps_pkg::STEP_W-1:0]        new_step;
  logic [PW:0]                        limit_ext;
  logic [PW:0]                        step_ext;
  logic signed [PW:0]                 moved;
  logic [PW+15:0]                     pos_wide;

  assign in_ready = (state == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_min <= srps_pkg::EXT_MIN_RST;
      ext_max <= srps_pkg::EXT_MAX_RST;
      int_min <= srps_pkg::INT_MIN_RST;
      int_max <= srps_pkg::INT_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srps_pkg::REG_EXT_MIN: ext_min <= cfg_data;
        srps_pkg::REG_EXT_MAX: ext_max <= cfg_data;
        srps_pkg::REG_INT_MIN: int_min <= cfg_data;
        srps_pkg::REG_INT_MAX: int_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // divider operands are magnitudes; sign handled at fix-up
  assign prod_mag = prod[MW-1] ? MW'(-prod) : MW'(prod);
  assign span_mag = span[srps_pkg::DIFF_W-1] ? srps_pkg::DIFF_W'(-span)
                                              : srps_pkg::DIFF_W'(span);
  assign div_start = (state == ST_LOAD) && !zero_span && !div_stat.busy;

  srps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[srps_pkg::DVD_W-1:0]),
    .divisor  (span_mag[srps_pkg::DSR_W-1:0]),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // quotient sign and offset; saturation applied at fix-up
  always_comb begin
    q_use = zero_span ? '0 : div_q;
    q_ext = {{(MW - srps_pkg::DVD_W){1'b0}}, q_use};
    q_sgn = neg ? -q_ext : q_ext;
    map_sum = q_sgn + {{(MW - srps_pkg::CFG_W){int_min[srps_pkg::CFG_W-1]}}, int_min};
  end

  // shared distance subtractor: against the new value or the current target
  always_comb begin
    sub_rhs = (state == ST_TGT) ? {mapped[PW-1], mapped}
                                : {target_position[PW-1], target_position};
    delta = {current_position[PW-1], current_position} - sub_rhs;
    gap_abs = delta[PW] ? (PW+1)'(-delta) : (PW+1)'(delta);
    new_step = (|gap_abs[PW:7]) ? srps_pkg::STEP_MAX : gap_abs[6:4];
    limit_ext = {{(PW + 1 - srps_pkg::LIMIT_W){1'b0}}, slowdown_limit};
    step_ext = {{(PW + 1 - srps_pkg::STEP_W){1'b0}}, step_width};
    moved = dir_down ? {current_position[PW-1], current_position} - step_ext
                     : {current_position[PW-1], current_position} + step_ext;
    pos_wide = {{16{current_position[PW-1]}}, current_position};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= (action == srps_pkg::ACT_TICK) ? ST_TICK : ST_MUL;
          end
        end
        ST_MUL:  state <= ST_LOAD;
        ST_LOAD: state <= zero_span ? ST_FIX : ST_DIV;
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_FIX;
          end
        end
        ST_FIX:  state <= ST_TGT;
        ST_TGT:  state <= ST_DONE;
        ST_TICK: state <= (current_position == target_position) ? ST_DONE : ST_MOVE;
        ST_MOVE: state <= ST_DONE;
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // mapping datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      num_a <= {command_value[15], command_value} - {ext_min[15], ext_min};
      num_b <= {int_max[15], int_max} - {int_min[15], int_min};
      span <= {ext_max[15], ext_max} - {ext_min[15], ext_min};
      zero_span <= (ext_max == ext_min);
    end
    if (state == ST_MUL) begin
      prod <= num_a * num_b;
    end
    if (state == ST_LOAD) begin
      neg <= prod[MW-1] ^ span[srps_pkg::DIFF_W-1];
    end
    if (state == ST_FIX) begin
      if (map_sum > MAP_MAX) begin
        mapped <= POS_MAX;
      end else if (map_sum < MAP_MIN) begin
        mapped <= POS_MIN;
      end else begin
        mapped <= map_sum[PW-1:0];
      end
    end
    if (state == ST_TICK) begin
      dir_down <= !delta[PW];
    end
  end

  // motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      current_position <= '0;
      step_width <= '0;
      slowdown_limit <= '0;
    end else begin
      // new target: fresh step and slow-down limit
      if ((state == ST_TGT) && (mapped != target_position)) begin
        target_position <= mapped;
        slowdown_limit <= srps_pkg::slow_limit(new_step);
        step_width <= (new_step == '0) ? srps_pkg::STEP_W'(1) : new_step;
      end
      // tick: shrink step inside the slow-down zone
      if ((state == ST_TICK) && (current_position != target_position)
          && (gap_abs < limit_ext) && (step_width > srps_pkg::STEP_W'(1))) begin
        step_width <= step_width - 1'b1;
      end
      // tick: move with saturation
      if (state == ST_MOVE) begin
        if (moved[PW] != moved[PW-1]) begin
          current_position <= moved[PW] ? POS_MIN : POS_MAX;
        end else begin
          current_position <= moved[PW-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      position <= pos_wide[15:0];
      at_target <= (current_position == target_position);
      step_size <= step_width;
    end
  end

endmodule

// File: hw/rtl/srps_div.sv
// unsigned restoring divider, two quotient bits per cycle
// depends on srps_pkg
module srps_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srps_pkg::DVD_W-1:0]    dividend,
  input  logic [srps_pkg::DSR_W-1:0]    divisor,
  output logic [srps_pkg::DVD_W-1:0]    quotient,
  output srps_pkg::div_stat_t           stat
);

  logic [srps_pkg::DVD_W-1:0]     dvd;
  logic [srps_pkg::DSR_W-1:0]     rem;
  logic [srps_pkg::DSR_W-1:0]     dsr;
  logic [srps_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [srps_pkg::DSR_W:0]       s1;
  logic [srps_pkg::DSR_W:0]       s2;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [srps_pkg::DSR_W:0] div_step(
    input logic [srps_pkg::DSR_W-1:0] r,
    input logic                       b,
    input logic [srps_pkg::DSR_W-1:0] d
  );
    logic [srps_pkg::DSR_W:0]   sh;
    logic [srps_pkg::DSR_W+1:0] t;
    sh = {r, b};
    t = {1'b0, sh} - {2'b00, d};
    if (!t[srps_pkg::DSR_W+1]) begin
      return {1'b1, t[srps_pkg::DSR_W-1:0]};
    end
    return {1'b0, sh[srps_pkg::DSR_W-1:0]};
  endfunction

  // two chained steps per cycle
  always_comb begin
    s1 = div_step(rem, dvd[srps_pkg::DVD_W-1], dsr);
    s2 = div_step(s1[srps_pkg::DSR_W-1:0], dvd[srps_pkg::DVD_W-2], dsr);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt <= srps_pkg::DIV_LAST;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: dividend shifts out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[srps_pkg::DVD_W-3:0], s1[srps_pkg::DSR_W], s2[srps_pkg::DSR_W]};
      rem <= s2[srps_pkg::DSR_W-1:0];
    end
  end

  assign quotient = dvd;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: hw/rtl/srps_checker.sv
// port-level checks for the servo ramp position stepper, bound to the top level
// depends on servo_ramp_position_stepper_defines.svh and srps_pkg
`include "servo_ramp_position_stepper_defines.svh"

module srps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [15:0]            position,
  input logic                          at_target,
  input logic [srps_pkg::STEP_W-1:0]   step_size
);

  // leaving reset: idle and nothing to deliver
  `SRPS_CHK_NOW(a_reset_idle, $past(rst), !out_valid && in_ready, "not idle after reset")

  // a taken word keeps the block busy for at least the next cycle
  `SRPS_CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // a stalled result holds
  `SRPS_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(at_target) && $stable(step_size), "stalled result changed")

endmodule

bind servo_ramp_position_stepper srps_checker u_srps_checker (.*);

// File: bench/servo_ramp_position_stepper_tb.sv
// testbench for servo_ramp_position_stepper: random move and tick words under
// random stalls, checked against a ramp predictor held in a scoreboard class
// depends on srps_pkg and the servo_ramp_position_stepper module
`timescale 1ns / 1ps

module servo_ramp_position_stepper_tb;

  localparam longint POS_TOP = 32767;
  localparam longint POS_BOT = -32768;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS = 145;
  localparam int N_RANGES = 8;

  typedef struct packed {
    logic signed [15:0]          position;
    logic                        at_target;
    logic [srps_pkg::STEP_W-1:0] step_size;
  } ramp_result_t;

  // ramp predictor and store of expected results
  class ramp_scoreboard;
    logic signed [15:0] ext_lo, ext_hi, int_lo, int_hi;
    longint tgt_pos, cur_pos;
    logic [srps_pkg::STEP_W-1:0] step_w;
    logic [srps_pkg::LIMIT_W-1:0] slow_lim;
    ramp_result_t want_q[$];
    int errors, checked, moves, ticks, arrivals;

    function new();
      ext_lo = srps_pkg::EXT_MIN_RST;
      ext_hi = srps_pkg::EXT_MAX_RST;
      int_lo = srps_pkg::INT_MIN_RST;
      int_hi = srps_pkg::INT_MAX_RST;
      tgt_pos = 0;
      cur_pos = 0;
      step_w = '0;
      slow_lim = '0;
    endfunction

    function void set_reg(logic [srps_pkg::CFG_IDX_W-1:0] idx, logic signed [15:0] val);
      case (idx)
        srps_pkg::REG_EXT_MIN: ext_lo = val;
        srps_pkg::REG_EXT_MAX: ext_hi = val;
        srps_pkg::REG_INT_MIN: int_lo = val;
        srps_pkg::REG_INT_MAX: int_hi = val;
        default: ;
      endcase
    endfunction

    function longint clamp_pos(longint v);
      if (v > POS_TOP) return POS_TOP;
      if (v < POS_BOT) return POS_BOT;
      return v;
    endfunction

    // linear rescale, truncating toward zero; zero-width range gives int_lo
    function longint scale_cmd(logic signed [15:0] v);
      longint span_in, num;
      span_in = longint'(ext_hi) - longint'(ext_lo);
      if (span_in == 0) return clamp_pos(longint'(int_lo));
      num = (longint'(v) - longint'(ext_lo)) * (longint'(int_hi) - longint'(int_lo));
      return clamp_pos(num / span_in + longint'(int_lo));
    endfunction

    function bit settled();
      return cur_pos == tgt_pos;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // advance the ramp by one accepted word and queue its result
    function void note_word(logic act, logic signed [15:0] val);
      longint nv, gap, delta;
      int s;
      ramp_result_t r;
      if (act == srps_pkg::ACT_MOVE) begin
        moves++;
        nv = scale_cmd(val);
        if (nv != tgt_pos) begin
          tgt_pos = nv;
          gap = cur_pos - tgt_pos;
          if (gap < 0) gap = -gap;
          gap = gap / 16;
          s = (gap > 7) ? 7 : int'(gap);
          slow_lim = srps_pkg::LIMIT_W'(s * (s + 1) / 2 + 1);
          step_w = (s == 0) ? srps_pkg::STEP_W'(1) : srps_pkg::STEP_W'(s);
        end
      end else begin
        ticks++;
        if (cur_pos != tgt_pos) begin
          delta = cur_pos - tgt_pos;
          // inside the slow-down zone the step shrinks first
          if (((delta < 0) ? -delta : delta) < longint'(slow_lim) && step_w > 1)
            step_w = step_w - 1'b1;
          if (delta > 0) cur_pos = clamp_pos(cur_pos - longint'(step_w));
          else cur_pos = clamp_pos(cur_pos + longint'(step_w));
          if (cur_pos == tgt_pos) arrivals++;
        end
      end
      r.position = 16'(cur_pos);
      r.at_target = (cur_pos == tgt_pos);
      r.step_size = step_w;
      want_q.push_back(r);
    endfunction

    function void check(logic signed [15:0] pos, logic at,
                        logic [srps_pkg::STEP_W-1:0] st);
      ramp_result_t w;
      if (want_q.size() == 0) begin
        $error("result with nothing expected: position %0d", pos);
        errors++;
        return;
      end
      w = want_q.pop_front();
      checked++;
      if (pos !== w.position) begin
        $error("position: expected %0d, got %0d", w.position, pos);
        errors++;
      end
      if (at !== w.at_target) begin
        $error("at_target: expected %0d, got %0d", w.at_target, at);
        errors++;
      end
      if (st !== w.step_size) begin
        $error("step_size: expected %0d, got %0d", w.step_size, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [srps_pkg::CFG_IDX_W-1:0] cfg_index = srps_pkg::REG_EXT_MIN;
  logic [srps_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = srps_pkg::ACT_MOVE;
  logic signed [15:0] command_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] position;
  logic at_target;
  logic [srps_pkg::STEP_W-1:0] step_size;

  ramp_scoreboard sb;
  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int n_ranges = 0;

  servo_ramp_position_stepper dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .command_value(command_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .position(position),
    .at_target(at_target),
    .step_size(step_size)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, calm stretches and one long hold
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (snk_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 22);
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check(position, at_target, step_size);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one word, starting and ending at a falling edge
  task automatic send_word(input logic act, input logic signed [15:0] val);
    while (!src_calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    command_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_word(act, val);
    @(negedge clk);
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic put_reg(input logic [srps_pkg::CFG_IDX_W-1:0] idx,
                         input logic signed [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_ranges(input logic signed [15:0] e_lo, input logic signed [15:0] e_hi,
                            input logic signed [15:0] i_lo, input logic signed [15:0] i_hi);
    put_reg(srps_pkg::REG_EXT_MIN, e_lo);
    put_reg(srps_pkg::REG_EXT_MAX, e_hi);
    put_reg(srps_pkg::REG_INT_MIN, i_lo);
    put_reg(srps_pkg::REG_INT_MAX, i_hi);
    cfg_wr_en <= 1'b0;
    n_ranges++;
  endtask

  // command value: mostly inside the external range, some at its ends, some anywhere
  function automatic logic signed [15:0] pick_command();
    int lo, hi, r;
    lo = (sb.ext_lo < sb.ext_hi) ? int'(sb.ext_lo) : int'(sb.ext_hi);
    hi = (sb.ext_lo < sb.ext_hi) ? int'(sb.ext_hi) : int'(sb.ext_lo);
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom);
    if (r < 12) return 16'(lo);
    if (r < 16) return 16'(hi);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // moves followed by runs of ticks, with stray ticks and back-to-back moves
  task automatic run_phase(input int n_words);
    int sent, run, r;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_word(srps_pkg::ACT_TICK, 16'($urandom));
        sent++;
      end else begin
        send_word(srps_pkg::ACT_MOVE, pick_command());
        sent++;
        if (r < 35) begin
          // ramp until the target is reached, at most 80 ticks
          run = 80;
          while (run > 0 && !sb.settled() && sent < n_words) begin
            send_word(srps_pkg::ACT_TICK, 16'($urandom));
            sent++;
            run--;
          end
        end else begin
          run = $urandom_range(0, 20);
          while (run > 0 && sent < n_words) begin
            send_word(srps_pkg::ACT_TICK, 16'($urandom));
            sent++;
            run--;
          end
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset ranges: tick and move at rest, long ramp, field extremes
    send_word(srps_pkg::ACT_TICK, 16'sd0);
    send_word(srps_pkg::ACT_MOVE, 16'sd0);
    send_word(srps_pkg::ACT_MOVE, 16'sd180);
    repeat (4) send_word(srps_pkg::ACT_TICK, -16'sd1);
    send_word(srps_pkg::ACT_MOVE, 16'sd179);
    repeat (3) send_word(srps_pkg::ACT_TICK, 16'sd0);
    send_word(srps_pkg::ACT_MOVE, -16'sd32768);
    send_word(srps_pkg::ACT_TICK, 16'sd32767);
    send_word(srps_pkg::ACT_MOVE, 16'sd32767);
    send_word(srps_pkg::ACT_TICK, -16'sd32768);
    send_word(srps_pkg::ACT_MOVE, -16'sd1);
    send_word(srps_pkg::ACT_TICK, 16'sd0);
    drain();

    // zero-width external range maps everything to the internal minimum
    set_ranges(16'sd50, 16'sd50, 16'sd7, 16'sd200);
    send_word(srps_pkg::ACT_MOVE, 16'sd32767);
    send_word(srps_pkg::ACT_TICK, 16'sd0);
    send_word(srps_pkg::ACT_MOVE, -16'sd32768);
    drain();

    // steep gain: the mapped target saturates both ways
    set_ranges(16'sd10, 16'sd20, -16'sd32768, 16'sd32767);
    send_word(srps_pkg::ACT_MOVE, 16'sd32767);
    send_word(srps_pkg::ACT_TICK, 16'sd0);
    send_word(srps_pkg::ACT_MOVE, -16'sd32768);
    send_word(srps_pkg::ACT_TICK, 16'sd0);
    drain();

    for (int p = 0; p < N_RANGES; p++) begin
      case (p)
        0: set_ranges(-16'sd100, 16'sd100, -16'sd300, 16'sd300);
        1: set_ranges(16'sd0, 16'sd1000, 16'sd500, -16'sd500);
        2: set_ranges(16'sd50, 16'sd50, 16'sd7, 16'sd200);
        3: set_ranges(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        4: set_ranges(16'sd32767, -16'sd32768, 16'sd100, -16'sd100);
        5: set_ranges(16'sd10, 16'sd20, -16'sd32768, 16'sd32767);
        6: set_ranges(-16'sd5, 16'sd5, -16'sd40, 16'sd40);
        default: set_ranges(srps_pkg::EXT_MIN_RST, srps_pkg::EXT_MAX_RST,
                            srps_pkg::INT_MIN_RST, srps_pkg::INT_MAX_RST);
      endcase
      // long result-side hold while words keep coming
      if (p == 1) hold_req = 1'b1;
      // stretch without any idling
      src_calm = (p == 6);
      snk_calm = (p == 6);
      run_phase(PHASE_WORDS);
      drain();
    end
    src_calm = 1'b0;
    snk_calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d move and %0d tick words, %0d results checked, %0d arrivals",
             sb.moves, sb.ticks, sb.checked, sb.arrivals);
    $display("over %0d range settings incl. zero-width, reversed and full-scale",
             n_ranges);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/srps_pkg.sv
hw/rtl/srps_div.sv
hw/rtl/servo_ramp_position_stepper.sv
hw/rtl/srps_checker.sv
bench/servo_ramp_position_stepper_tb.sv
